// ===== hdl/csec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csec_pkg: shared types and constants for the civil date converter
// calendar tables, field widths, register indexes and stage payload structs
// ----------------------------------------------------------------------------
package csec_pkg;

    localparam int unsigned DAY_W    = 17;  // day index since 2000-01-01
    localparam int unsigned TOD_W    = 17;  // seconds within a day, up to 86400
    localparam int unsigned LEAP_W   = 17;  // leap-second day registers
    localparam int unsigned USED_W   = 2;
    localparam int unsigned TOTAL_W  = 33;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [DAY_W-1:0] SECS_PER_DAY = 17'd86400;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_LEAP_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAP_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEAP_THIRD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAP_USED   = 2'd3;

    localparam logic [LEAP_W-1:0] LEAP_FIRST_RST  = 17'd2191;
    localparam logic [LEAP_W-1:0] LEAP_SECOND_RST = 17'd3287;
    localparam logic [LEAP_W-1:0] LEAP_THIRD_RST  = 17'd4564;
    localparam logic [USED_W-1:0] LEAP_USED_RST   = 2'd3;

    // after range checks and day count
    typedef struct packed {
        logic             ok;
        logic             sec60;      // second field is 60
        logic             last_min;   // 23:59
        logic [DAY_W-1:0] days;
        logic [TOD_W-1:0] tod;
    } stage1_t;

    // after the leap table scan
    typedef struct packed {
        logic              ok;
        logic [USED_W-1:0] extra;
        logic [DAY_W-1:0]  days;
        logic [TOD_W-1:0]  tod;
    } stage2_t;

    // month length with feb at 29, zero for months that do not exist
    function automatic logic [4:0] month_len(input logic [3:0] mo);
        logic [4:0] len;
        case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd29;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the year before the first of the month, non-leap year
    function automatic logic [8:0] days_before_month(input logic [3:0] mo);
        logic [8:0] dbm;
        case (mo)
            4'd1:    dbm = 9'd0;
            4'd2:    dbm = 9'd31;
            4'd3:    dbm = 9'd59;
            4'd4:    dbm = 9'd90;
            4'd5:    dbm = 9'd120;
            4'd6:    dbm = 9'd151;
            4'd7:    dbm = 9'd181;
            4'd8:    dbm = 9'd212;
            4'd9:    dbm = 9'd243;
            4'd10:   dbm = 9'd273;
            4'd11:   dbm = 9'd304;
            4'd12:   dbm = 9'd334;
            default: dbm = 9'd0;
        endcase
        return dbm;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/csec_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csec_calc: field checks and day count
// range checks, leap-year rule, day index and seconds of the day, registered
// ----------------------------------------------------------------------------
module csec_calc (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       year_offset,
    input  wire logic [3:0]       month,
    input  wire logic [4:0]       day_of_month,
    input  wire logic [4:0]       hour,
    input  wire logic [5:0]       minute,
    input  wire logic [5:0]       second,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output csec_pkg::stage1_t     out_data
);

    logic                       valid_reg;
    csec_pkg::stage1_t          data_reg;
    csec_pkg::stage1_t          data_next;
    logic                       leap_year;
    logic [csec_pkg::DAY_W-1:0] year_days;
    logic [6:0]                 quad_cnt;
    logic [1:0]                 cent_cnt;
    logic                       qcent_cnt;
    logic [4:0]                 mlen;
    logic                       range_ok;

    // 2000 is a leap year, 2100 and 2200 are not
    assign leap_year = (year_offset[1:0] == 2'd0) && (year_offset != 8'd100)
                       && (year_offset != 8'd200);

    assign quad_cnt  = 7'(({1'b0, year_offset} + 9'd3) >> 2);
    assign cent_cnt  = (year_offset == 8'd0)   ? 2'd0 :
                       (year_offset <= 8'd100) ? 2'd1 :
                       (year_offset <= 8'd200) ? 2'd2 : 2'd3;
    assign qcent_cnt = (year_offset != 8'd0);

    assign year_days = 17'({9'd0, year_offset} * 17'd365) + 17'(quad_cnt)
                       - 17'(cent_cnt) + 17'(qcent_cnt);

    assign mlen = csec_pkg::month_len(month);

    always_comb begin
        range_ok = (mlen != 5'd0) && (day_of_month != 5'd0) && (day_of_month <= mlen)
                   && (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd60);
        // feb 29 outside a leap year
        if ((month == 4'd2) && (day_of_month == 5'd29) && !leap_year) begin
            range_ok = 1'b0;
        end
        data_next.ok       = range_ok;
        data_next.sec60    = (second == 6'd60);
        data_next.last_min = (hour == 5'd23) && (minute == 6'd59);
        data_next.days     = year_days + 17'(csec_pkg::days_before_month(month))
                             + 17'(day_of_month) - 17'd1
                             + 17'((month > 4'd2) && leap_year);
        data_next.tod      = 17'({12'd0, hour} * 17'd3600) + 17'({11'd0, minute} * 17'd60)
                             + 17'(second);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/csec_leap.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csec_leap: leap-second table scan
// counts passed leap-second days and checks second 60, registered
// ----------------------------------------------------------------------------
module csec_leap (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [csec_pkg::LEAP_W-1:0] leap_day_first,
    input  wire logic [csec_pkg::LEAP_W-1:0] leap_day_second,
    input  wire logic [csec_pkg::LEAP_W-1:0] leap_day_third,
    input  wire logic [csec_pkg::USED_W-1:0] leap_entries_used,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire csec_pkg::stage1_t           in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output csec_pkg::stage2_t                out_data
);

    logic                          valid_reg;
    csec_pkg::stage2_t             data_reg;
    csec_pkg::stage2_t             data_next;
    logic [csec_pkg::LEAP_W-1:0]   entry [3];
    logic [csec_pkg::USED_W-1:0]   extra;
    logic                          today_ls;
    logic                          scan_on;

    assign entry[0] = leap_day_first;
    assign entry[1] = leap_day_second;
    assign entry[2] = leap_day_third;

    // scan stops at the first entry past the current day
    always_comb begin
        extra    = '0;
        today_ls = 1'b0;
        scan_on  = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (scan_on && (leap_entries_used > 2'(i))) begin
                if (in_data.days < entry[i]) begin
                    scan_on = 1'b0;
                end else if (in_data.days > entry[i]) begin
                    extra = extra + 2'd1;
                end else begin
                    today_ls = 1'b1;
                end
            end
        end
        data_next.ok    = in_data.ok && (!in_data.sec60 || (today_ls && in_data.last_min));
        data_next.extra = extra;
        data_next.days  = in_data.days;
        data_next.tod   = in_data.tod;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // passed leap days never exceed the entries in use
    a_extra_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> (3'(extra) + 3'(today_ls) <= 3'(leap_entries_used)))
        else $error("leap count exceeds entries in use");

endmodule

`default_nettype wire

// ===== hdl/csec_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csec_sum: final seconds sum
// zero for a rejected request, else day index times seconds per day plus time of day and leap count
// ----------------------------------------------------------------------------
module csec_sum (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire csec_pkg::stage2_t            in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [csec_pkg::TOTAL_W-1:0]      total_seconds,
    output logic                              valid_res
);

    logic                          valid_reg;
    logic [csec_pkg::TOTAL_W-1:0]  total_reg;
    logic [csec_pkg::TOTAL_W-1:0]  total_next;
    logic                          res_ok_reg;
    logic [2*csec_pkg::DAY_W-1:0]  day_secs;

    assign day_secs   = in_data.days * csec_pkg::SECS_PER_DAY;
    assign total_next = in_data.ok
                        ? 33'(day_secs) + 33'(in_data.tod) + 33'(in_data.extra)
                        : '0;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            total_reg  <= total_next;
            res_ok_reg <= in_data.ok;
        end
    end

    assign out_valid     = valid_reg;
    assign total_seconds = total_reg;
    assign valid_res     = res_ok_reg;

endmodule

`default_nettype wire

// ===== hdl/civil_date_to_seconds.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// civil_date_to_seconds: civil date and time to seconds since 2000-01-01
// three-stage pipeline with configurable leap-second days
// ----------------------------------------------------------------------------
// usage
//   s_ channel carries one request per date: year offset, month, day, hour,
//   minute and second packed in s_tdata. m_ channel returns one result per
//   request, in order: total seconds and a valid flag in m_tdata.
//   a request that fails any check returns zero seconds with valid_res low.
//   a result reaches m_tvalid through three register stages (checks and day
//   count, leap scan, final sum). throughput: one request per cycle while
//   m_tready stays high; each stage holds its own valid bit and is ready
//   when empty or when the stage after it moves on.
//   when m_tready is low the result waits in the output register and the
//   upstream stages keep filling until every stage holds a request; then
//   s_tready drops and nothing is lost or repeated.
//   reset (aresetn low, synchronous) empties all stages and loads the leap
//   registers with their defaults; no clearing pass is needed.
//   config writes (cfg_wr_en) take effect on the next edge and are meant
//   for an idle pipeline.
// ----------------------------------------------------------------------------
module civil_date_to_seconds (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // config write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [csec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [csec_pkg::LEAP_W-1:0]    cfg_wdata,
    // request channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // year_offset[7:0], month[11:8], day_of_month[16:12], hour[21:17],
    // minute[27:22], second[33:28], zero fill[39:34]
    input  wire logic [csec_pkg::IN_TDATA_W-1:0]  s_tdata,
    // result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // total_seconds[32:0], valid_res[33], zero fill[39:34]
    output logic [csec_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // leap-second registers
    logic [csec_pkg::LEAP_W-1:0] leap_first_reg;
    logic [csec_pkg::LEAP_W-1:0] leap_second_reg;
    logic [csec_pkg::LEAP_W-1:0] leap_third_reg;
    logic [csec_pkg::USED_W-1:0] leap_used_reg;

    // stage links
    logic              s1_valid;
    logic              s1_ready;
    csec_pkg::stage1_t s1_data;
    logic              s2_valid;
    logic              s2_ready;
    csec_pkg::stage2_t s2_data;
    logic [csec_pkg::TOTAL_W-1:0] total_seconds;
    logic              valid_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leap_first_reg  <= csec_pkg::LEAP_FIRST_RST;
            leap_second_reg <= csec_pkg::LEAP_SECOND_RST;
            leap_third_reg  <= csec_pkg::LEAP_THIRD_RST;
            leap_used_reg   <= csec_pkg::LEAP_USED_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                csec_pkg::REG_LEAP_FIRST:  leap_first_reg  <= cfg_wdata;
                csec_pkg::REG_LEAP_SECOND: leap_second_reg <= cfg_wdata;
                csec_pkg::REG_LEAP_THIRD:  leap_third_reg  <= cfg_wdata;
                csec_pkg::REG_LEAP_USED:   leap_used_reg   <= cfg_wdata[csec_pkg::USED_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: checks, day index, time of day
    csec_calc u_calc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .year_offset  (s_tdata[7:0]),
        .month        (s_tdata[11:8]),
        .day_of_month (s_tdata[16:12]),
        .hour         (s_tdata[21:17]),
        .minute       (s_tdata[27:22]),
        .second       (s_tdata[33:28]),
        .out_valid    (s1_valid),
        .out_ready    (s1_ready),
        .out_data     (s1_data)
    );

    // stage 2: leap table scan and second 60 check
    csec_leap u_leap (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .leap_day_first    (leap_first_reg),
        .leap_day_second   (leap_second_reg),
        .leap_day_third    (leap_third_reg),
        .leap_entries_used (leap_used_reg),
        .in_valid          (s1_valid),
        .in_ready          (s1_ready),
        .in_data           (s1_data),
        .out_valid         (s2_valid),
        .out_ready         (s2_ready),
        .out_data          (s2_data)
    );

    // stage 3: seconds sum into the output register
    csec_sum u_sum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s2_valid),
        .in_ready      (s2_ready),
        .in_data       (s2_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .total_seconds (total_seconds),
        .valid_res     (valid_res)
    );

    assign m_tdata = {6'd0, valid_res, total_seconds};

    // rejected requests report zero seconds
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !valid_res) |-> (total_seconds == '0))
        else $error("rejected result carries nonzero seconds");

    // an empty output stage means the whole pipeline can take a request
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("pipeline stalled with empty output");

endmodule

`default_nettype wire
